### rtl/mspid_pkg.sv
// Shared types and constants for the motor speed PID block.
package mspid_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_W = 33;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAW, ST_FA, ST_FB, ST_MEAS, ST_G0, ST_G1, ST_G2, ST_PWM
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_RAW, OP_FA, OP_FB, OP_MEAS, OP_G0, OP_G1, OP_G2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic fin;
    logic pwm;
  } cmd_t;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_G0 = 3'd1;
  localparam logic [2:0] REG_G1 = 3'd2;
  localparam logic [2:0] REG_G2 = 3'd3;
  localparam logic [2:0] REG_RPT = 3'd4;
  localparam logic [2:0] REG_PPR = 3'd5;
  localparam logic [2:0] REG_TOP = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) return 32'sh7fffffff;
    if (x < -80'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // round to nearest, ties up: add half then arithmetic shift
  function automatic logic signed [79:0] rshr(input logic signed [79:0] x, input int s);
    if (s == 0) return x;
    return (x + (80'sd1 <<< (s - 1))) >>> s;
  endfunction
endpackage

### rtl/mspid_ctrl.sv
// Sequencer for the sample computation.
module mspid_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  output mspid_pkg::cmd_t cmd,
  output logic busy
);
  mspid_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mspid_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mspid_pkg::ST_IDLE: if (start) state_next = mspid_pkg::ST_RAW;
      mspid_pkg::ST_RAW: state_next = mspid_pkg::ST_FA;
      mspid_pkg::ST_FA: state_next = mspid_pkg::ST_FB;
      mspid_pkg::ST_FB: state_next = mspid_pkg::ST_MEAS;
      mspid_pkg::ST_MEAS: state_next = mspid_pkg::ST_G0;
      mspid_pkg::ST_G0: state_next = mspid_pkg::ST_G1;
      mspid_pkg::ST_G1: state_next = mspid_pkg::ST_G2;
      mspid_pkg::ST_G2: state_next = mspid_pkg::ST_PWM;
      mspid_pkg::ST_PWM: if (out_free) state_next = mspid_pkg::ST_IDLE;
      default: state_next = mspid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: mspid_pkg::OP_NONE, load: 1'b0, fin: 1'b0, pwm: 1'b0};
    busy = 1'b1;
    case (state)
      mspid_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      mspid_pkg::ST_RAW: cmd.op = mspid_pkg::OP_RAW;
      mspid_pkg::ST_FA: cmd.op = mspid_pkg::OP_FA;
      mspid_pkg::ST_FB: cmd.op = mspid_pkg::OP_FB;
      mspid_pkg::ST_MEAS: cmd.op = mspid_pkg::OP_MEAS;
      mspid_pkg::ST_G0: cmd.op = mspid_pkg::OP_G0;
      mspid_pkg::ST_G1: cmd.op = mspid_pkg::OP_G1;
      mspid_pkg::ST_G2: cmd.op = mspid_pkg::OP_G2;
      mspid_pkg::ST_PWM: begin
        cmd.pwm = out_free;
        cmd.fin = out_free;
      end
      default: busy = 1'b1;
    endcase
  end
endmodule

### rtl/mspid_dp.sv
// Datapath: shared multiplier, accumulator and PID state.
module mspid_dp #(
  parameter int FRAC_BITS = mspid_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  mspid_pkg::cmd_t cmd,
  input  logic signed [31:0] tick_now,
  input  logic [22:0] setpoint,
  input  logic [15:0] alpha,
  input  logic signed [23:0] g0,
  input  logic signed [23:0] g1,
  input  logic signed [23:0] g2,
  input  logic [31:0] rpt,
  input  logic [31:0] ppr,
  input  logic [15:0] top,
  output logic [15:0] pwm_level,
  output logic [22:0] drive_percent,
  output logic signed [31:0] error_percent,
  output logic signed [31:0] speed_rpm,
  output logic signed [31:0] tick_total
);
  localparam int RPM_SHIFT = 24 - FRAC_BITS;
  localparam logic signed [79:0] FULL = 80'sd100 <<< FRAC_BITS;
  // ceil(2^26 / 25): exact floor division by 25 for inputs below 2^21
  localparam logic [21:0] DIV25_MUL = 22'd2684355;

  logic signed [31:0] prev_ticks, smooth, e1, e2, drive, delta, raw, e0;
  logic signed [79:0] acc;
  logic signed [mspid_pkg::MUL_W-1:0] ma, mb;
  logic signed [79:0] prod, u;
  logic [63:0] pwm_full;
  logic [22:0] pwm_scaled;
  logic [42:0] pwm_prod;

  // one signed 33x33 multiplier shared by the RAW through G2 steps
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      mspid_pkg::OP_RAW: begin ma = 33'(delta); mb = {1'b0, rpt}; end
      mspid_pkg::OP_FA: begin ma = 33'(raw); mb = {17'd0, alpha}; end
      mspid_pkg::OP_FB: begin ma = 33'(smooth); mb = 33'(17'h10000 - {1'b0, alpha}); end
      mspid_pkg::OP_MEAS: begin ma = 33'(smooth); mb = {1'b0, ppr}; end
      mspid_pkg::OP_G0: begin ma = 33'(e0); mb = 33'(g0); end
      mspid_pkg::OP_G1: begin ma = 33'(e1); mb = 33'(g1); end
      mspid_pkg::OP_G2: begin ma = 33'(e2); mb = 33'(g2); end
      default: ;
    endcase
    prod = 80'(ma * mb);
    u = 80'(drive) + mspid_pkg::rshr(acc, 20);
    if (u > FULL) u = FULL;
    if (u < 0) u = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ticks <= '0;
      smooth <= '0;
      e1 <= '0;
      e2 <= '0;
      drive <= '0;
    end else begin
      if (cmd.load) begin
        delta <= tick_now - prev_ticks;
        prev_ticks <= tick_now;
      end
      case (cmd.op)
        mspid_pkg::OP_RAW: raw <= mspid_pkg::sat32(mspid_pkg::rshr(prod, RPM_SHIFT));
        mspid_pkg::OP_FA: acc <= prod;
        mspid_pkg::OP_FB: smooth <= mspid_pkg::sat32(mspid_pkg::rshr(acc + prod, 16));
        mspid_pkg::OP_MEAS:
          e0 <= mspid_pkg::sat32(80'({1'b0, setpoint})
                - 80'(mspid_pkg::sat32(mspid_pkg::rshr(prod, 24))));
        mspid_pkg::OP_G0: acc <= prod;
        mspid_pkg::OP_G1: acc <= acc + prod;
        mspid_pkg::OP_G2: acc <= acc + prod;
        default: ;
      endcase
      if (cmd.pwm) begin
        drive <= u[31:0];
        e2 <= e1;
        e1 <= e0;
        drive_percent <= u[22:0];
        pwm_full <= 64'(u[31:0]) * 64'(top);
        error_percent <= e0;
        speed_rpm <= smooth;
        tick_total <= prev_ticks;
      end
    end
  end

  // divide by 100 << FRAC_BITS: drop the fraction, divide by 4, then by 25
  // through a reciprocal multiply; the scaled value stays below 100 * 65536
  assign pwm_scaled = 23'(pwm_full >> FRAC_BITS);
  assign pwm_prod = 43'(pwm_scaled[22:2]) * 43'(DIV25_MUL);
  assign pwm_level = pwm_prod[41:26];
endmodule

### rtl/motor_speed_pid_with_encoder.sv
// Top level: quadrature tick counter plus incremental PID speed controller.
// Edge word: no result, taken every cycle while idle.
// Sample word: result valid after the RAW, FA, FB, MEAS, G0, G1 and G2
// shared-multiplier steps and the PWM step; no new word is taken before the PWM step completes.
// A result held by out_stall delays only the final step of the next sample.
// Synchronous active-high reset clears tick count, sequencer, filter/PID state and out_valid; loads the default config.
module motor_speed_pid_with_encoder #(
  parameter int FRAC_BITS = mspid_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic edge_on_b,
  input  logic level_a,
  input  logic level_b,
  input  logic [22:0] target_speed,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] pwm_level,
  output logic [22:0] drive_percent,
  output logic signed [31:0] error_percent,
  output logic signed [31:0] speed_rpm,
  output logic signed [31:0] tick_total,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [15:0] alpha, top;
  logic signed [23:0] g0, g1, g2;
  logic [31:0] rpt, ppr;
  logic signed [31:0] ticks;
  logic [22:0] setpoint;
  logic busy, start, acc_in, outv;
  mspid_pkg::cmd_t cmd_w;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 16'd9830;
      g0 <= 24'sd860467;
      g1 <= -24'sd704218;
      g2 <= 24'sd196;
      rpt <= 32'd2396745;
      ppr <= 32'd8388608;
      top <= 16'd12499;
    end else if (cfg_we) begin
      case (cfg_index)
        mspid_pkg::REG_ALPHA: alpha <= cfg_data[15:0];
        mspid_pkg::REG_G0: g0 <= cfg_data[23:0];
        mspid_pkg::REG_G1: g1 <= cfg_data[23:0];
        mspid_pkg::REG_G2: g2 <= cfg_data[23:0];
        mspid_pkg::REG_RPT: rpt <= cfg_data;
        mspid_pkg::REG_PPR: ppr <= cfg_data;
        mspid_pkg::REG_TOP: top <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign acc_in = in_valid && !busy;
  assign start = acc_in && cmd;

  // quadrature count: x != channel counts up
  always_ff @(posedge clk) begin
    if (rst) ticks <= '0;
    else if (acc_in && !cmd)
      ticks <= ((level_a ^ level_b) != edge_on_b) ? ticks + 32'sd1 : ticks - 32'sd1;
  end

  always_ff @(posedge clk) begin
    if (start) setpoint <= target_speed;
  end

  // result valid from PWM step until taken; PWM step waits for a free slot
  always_ff @(posedge clk) begin
    if (rst) outv <= 1'b0;
    else if (cmd_w.pwm) outv <= 1'b1;
    else if (outv && !out_stall) outv <= 1'b0;
  end
  assign out_valid = outv;

  mspid_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .out_free(!outv || !out_stall),
    .cmd(cmd_w), .busy(busy)
  );

  mspid_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd_w), .tick_now(ticks), .setpoint(setpoint),
    .alpha(alpha), .g0(g0), .g1(g1), .g2(g2), .rpt(rpt), .ppr(ppr), .top(top),
    .pwm_level(pwm_level), .drive_percent(drive_percent),
    .error_percent(error_percent), .speed_rpm(speed_rpm), .tick_total(tick_total)
  );
endmodule

### tb/motor_speed_pid_with_encoder_tb.sv
// Self-checking testbench for the encoder tick counter and incremental PID speed controller.
`timescale 1ns / 100ps

module motor_speed_pid_with_encoder_tb;
  localparam int FB = 16;
  localparam longint FULL = 64'sd100 << FB;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] pwm;
    logic [22:0] drive;
    logic signed [31:0] err;
    logic signed [31:0] speed;
    logic signed [31:0] ticks;
  } speed_word_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic cmd = 0, edge_on_b = 0, level_a = 0, level_b = 0;
  logic [22:0] target_speed = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] pwm_level;
  logic [22:0] drive_percent;
  logic signed [31:0] error_percent, speed_rpm, tick_total;
  logic cfg_we = 0;
  logic [2:0] cfg_index = mspid_pkg::REG_ALPHA;
  logic [31:0] cfg_data = 0;

  always #5 clk = ~clk;

  motor_speed_pid_with_encoder u_top (.*);

  // controller image: configuration
  logic [15:0] alpha_q;
  longint g_now, g_prev, g_prev2;
  logic [31:0] rpt_q, ppr_q;
  logic [15:0] top_q;
  // controller image: state
  logic [31:0] enc_count, enc_last;
  longint smooth_q, err1_q, err2_q, drive_q;

  speed_word_t pending_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;
  bit done = 0;

  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sx24(logic [31:0] v);
    return longint'($signed(v[23:0]));
  endfunction

  task automatic reset_image();
    alpha_q = 9830; g_now = 860467; g_prev = -704218; g_prev2 = 196;
    rpt_q = 2396745; ppr_q = 8388608; top_q = 12499;
    enc_count = 0; enc_last = 0; smooth_q = 0; err1_q = 0; err2_q = 0; drive_q = 0;
  endtask

  // predict one accepted word; sample words queue an expected speed word
  task automatic predict_word(logic c, logic onb, logic la, logic lb, logic [22:0] sp);
    longint delta, raw, meas, e0, acc, u;
    speed_word_t w;
    if (!c) begin
      if ((la ^ lb) != onb) enc_count = enc_count + 1;
      else enc_count = enc_count - 1;
      return;
    end
    delta = longint'($signed(enc_count - enc_last));
    enc_last = enc_count;
    raw = clamp32(round_shift(delta * longint'(rpt_q), 24 - FB));
    smooth_q = clamp32(round_shift(longint'(alpha_q) * raw
                                   + (64'sd65536 - longint'(alpha_q)) * smooth_q, 16));
    meas = clamp32(round_shift(smooth_q * longint'(ppr_q), 24));
    e0 = clamp32(longint'(sp) - meas);
    acc = g_now * e0 + g_prev * err1_q + g_prev2 * err2_q;
    u = drive_q + round_shift(acc, 20);
    if (u > FULL) u = FULL;
    if (u < 0) u = 0;
    drive_q = u;
    err2_q = err1_q;
    err1_q = e0;
    w.pwm = 16'((u * longint'(top_q)) / FULL);
    w.drive = u[22:0];
    w.err = e0[31:0];
    w.speed = smooth_q[31:0];
    w.ticks = enc_count;
    pending_words.push_back(w);
  endtask

  // send one word, with optional random gap before it; valid stays up
  // until the next word or an explicit release
  task automatic send_word(logic c, logic onb, logic la, logic lb, logic [22:0] sp);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1; cmd <= c; edge_on_b <= onb; level_a <= la; level_b <= lb;
    target_speed <= sp;
    do @(posedge clk); while (in_stall);
    predict_word(c, onb, la, lb, sp);
    @(negedge clk);
  endtask

  task automatic send_edge();
    send_word(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 23'($urandom));
  endtask

  task automatic send_sample(logic [22:0] sp);
    send_word(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), sp);
  endtask

  // wait for all results, then the block's latency, before touching config
  task automatic drain();
    in_valid <= 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    case (idx)
      mspid_pkg::REG_ALPHA: alpha_q = val[15:0];
      mspid_pkg::REG_G0: g_now = sx24(val);
      mspid_pkg::REG_G1: g_prev = sx24(val);
      mspid_pkg::REG_G2: g_prev2 = sx24(val);
      mspid_pkg::REG_RPT: rpt_q = val;
      mspid_pkg::REG_PPR: ppr_q = val;
      mspid_pkg::REG_TOP: top_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_defaults();
    write_reg(mspid_pkg::REG_ALPHA, 9830);
    write_reg(mspid_pkg::REG_G0, 860467);
    write_reg(mspid_pkg::REG_G1, 32'(-704218));
    write_reg(mspid_pkg::REG_G2, 196);
    write_reg(mspid_pkg::REG_RPT, 2396745);
    write_reg(mspid_pkg::REG_PPR, 8388608);
    write_reg(mspid_pkg::REG_TOP, 12499);
  endtask

  // a run of edges in one direction, then a sample
  task automatic spin_then_sample(int n, bit up, logic [22:0] sp);
    logic la, lb, onb;
    for (int i = 0; i < n; i++) begin
      onb = 1'($urandom); la = 1'($urandom);
      // x = la^lb must differ from onb to count up
      lb = up ? ((la ^ ~onb)) : (la ^ onb);
      send_word(1'b0, onb, la, lb, 23'($urandom));
    end
    send_sample(sp);
  endtask

  // check results as they are accepted
  always @(posedge clk) begin
    speed_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (pwm_level !== w.pwm) begin
          $error("pwm_level exp %0d got %0d", w.pwm, pwm_level); errors++;
        end
        if (drive_percent !== w.drive) begin
          $error("drive_percent exp %0d got %0d", w.drive, drive_percent); errors++;
        end
        if (error_percent !== w.err) begin
          $error("error_percent exp %0d got %0d", w.err, error_percent); errors++;
        end
        if (speed_rpm !== w.speed) begin
          $error("speed_rpm exp %0d got %0d", w.speed, speed_rpm); errors++;
        end
        if (tick_total !== w.ticks) begin
          $error("tick_total exp %0d got %0d", w.ticks, tick_total); errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_sample(23'd0);
    send_sample(23'd6553600);
    send_sample(23'h7fffff);           // above full scale
    for (int i = 0; i < 8; i++) send_word(1'b0, i[0], i[1], i[2], 23'h7fffff);
    send_sample(23'd3276800);
    spin_then_sample(6, 1'b0, 23'd0);
    spin_then_sample(5, 1'b1, 23'd1);
    drain();
  endtask

  task automatic test_config_extremes();
    // max scaling drives rpm and percent into saturation
    write_reg(mspid_pkg::REG_ALPHA, 65535);
    write_reg(mspid_pkg::REG_G0, 32'h007fffff);
    write_reg(mspid_pkg::REG_G1, 32'h00800000);
    write_reg(mspid_pkg::REG_G2, 32'h00800000);
    write_reg(mspid_pkg::REG_RPT, 32'hffffffff);
    write_reg(mspid_pkg::REG_PPR, 32'hffffffff);
    write_reg(mspid_pkg::REG_TOP, 65535);
    for (int i = 0; i < 6; i++) spin_then_sample($urandom_range(0, 4), i[0], 23'($urandom));
    drain();
    write_reg(mspid_pkg::REG_ALPHA, 0);
    write_reg(mspid_pkg::REG_G0, 32'h00800000);
    write_reg(mspid_pkg::REG_G1, 32'h007fffff);
    write_reg(mspid_pkg::REG_G2, 32'h007fffff);
    write_reg(mspid_pkg::REG_RPT, 0);
    write_reg(mspid_pkg::REG_PPR, 0);
    write_reg(mspid_pkg::REG_TOP, 1);
    for (int i = 0; i < 6; i++) spin_then_sample(2, i[0], 23'($urandom));
    drain();
    write_reg(mspid_pkg::REG_TOP, 0);
    spin_then_sample(1, 1'b1, 23'd6553600);
    drain();
    load_defaults();
  endtask

  // mostly well-formed spin/sample sequences with random content
  task automatic test_random(int words, bit mixed_cfg);
    int sent = 0;
    int n;
    while (sent < words) begin
      if (mixed_cfg && $urandom_range(0, 40) == 0) begin
        drain();
        write_reg(3'($urandom_range(0, 6)), $urandom);
        if ($urandom_range(0, 1)) write_reg(mspid_pkg::REG_TOP, $urandom_range(1, 65535));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_edge(); sent++;
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        spin_then_sample(n, 1'($urandom),
                         $urandom_range(0, 3) == 0 ? 23'($urandom) : 23'($urandom_range(0, 6553600)));
        sent += n + 1;
      end
    end
  endtask

  task automatic test_drain_pause();
    // sender holds off until every result has come back
    spin_then_sample(3, 1'b1, 23'd3000000);
    in_valid <= 0;
    while (pending_words.size() != 0) @(negedge clk);
    spin_then_sample(3, 1'b0, 23'd100);
  endtask

  initial begin
    reset_image();
    repeat (6) @(negedge clk);
    rst <= 0;
    test_directed();
    test_config_extremes();
    test_random(800, 1'b0);
    test_drain_pause();
    test_random(700, 1'b1);
    drain();
    load_defaults();
    gaps_on = 0;
    test_random(400, 1'b0);
    in_valid <= 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    done = 1;
    if (errors == 0 && pending_words.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### files.f
rtl/mspid_pkg.sv
rtl/mspid_ctrl.sv
rtl/mspid_dp.sv
rtl/motor_speed_pid_with_encoder.sv
tb/motor_speed_pid_with_encoder_tb.sv
